// ===== design/sfw_pkg.sv =====
// Package: shared constants, register indexes and pipeline tag type for the falloff weight block.
package sfw_pkg;

    localparam int COORD_BITS_DEF       = 20;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int INV_FRAC_BITS   = 40;
    localparam int SQR_RADIUS_BITS = 42;
    localparam int INV_BITS        = 57;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = INV_BITS;

    // split points for the wide d2 * inv product
    localparam int A_LO_BITS = SQR_RADIUS_BITS / 2;
    localparam int B_LO_BITS = (INV_BITS + 1) / 2;
    localparam int PROD_BITS = SQR_RADIUS_BITS + INV_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SQR_RADIUS     = 8'd0,
        REG_INV_SQR_RADIUS = 8'd1
    } sfw_reg_t;

    typedef struct packed {
        logic valid;
        logic in_rad;
    } sfw_tag_t;

endpackage

// ===== design/spherical_falloff_weight.sv =====
// Spherical brush falloff weight: squared distance, radius test, normalise, square root.
//
// Takes one point word per cycle while the output is not stalled and returns one weight
// word per point, in order, sqrt(1 - d2/r^2) in Q1.16 (1.0 = 65536), zero with inside
// clear beyond the radius. The pipe has six arithmetic stages (difference, square,
// sum, radius test with partial products, product sum, normalise), one stage per
// root bit in the square root pipe, and the output register. The whole pipe
// advances together and holds while the output word is waiting, so s_tready is
// high while the output register is empty or m_tready is high. Registers: index 0
// sqr_radius, index 1 inv_sqr_radius (1/r^2, 40 fractional bits, 2^40 for a zero radius);
// write them only while no word is in flight.
module spherical_falloff_weight
    import sfw_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // brush_x, brush_y, brush_z, point_x, point_y, point_z
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // weight
    output logic [((WEIGHT_FRAC_BITS+8)/8)*8-1:0]     m_tdata,
    // inside_res
    output logic [0:0]                                m_tuser,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                  cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int W   = WEIGHT_FRAC_BITS;
    localparam int MDW = ((W + 8) / 8) * 8;
    localparam int SH  = INV_FRAC_BITS - W;
    localparam int D   = 2 * C + 2;
    localparam int CW  = (D > SQR_RADIUS_BITS) ? D : SQR_RADIUS_BITS;
    localparam int A_HI_BITS = SQR_RADIUS_BITS - A_LO_BITS;
    localparam int B_HI_BITS = INV_BITS - B_LO_BITS;
    localparam logic [W:0] ONE = (W + 1)'(1) << W;

    logic [SQR_RADIUS_BITS-1:0] sqr_radius_reg;
    logic [INV_BITS-1:0]        inv_sqr_radius_reg;

    logic ce;

    assign cfg_ready = 1'b1;
    assign s_tready  = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqr_radius_reg     <= '0;
            inv_sqr_radius_reg <= INV_BITS'(1) << INV_FRAC_BITS;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SQR_RADIUS) begin
                sqr_radius_reg <= cfg_data[SQR_RADIUS_BITS-1:0];
            end else if (cfg_index == REG_INV_SQR_RADIUS) begin
                inv_sqr_radius_reg <= cfg_data[INV_BITS-1:0];
            end
        end
    end

    // stage 1 and 2: per-axis magnitude of difference, then square
    logic           s1_valid_reg;
    logic           s2_valid_reg;
    logic [C:0]     mag_reg [0:2];
    logic [D-1:0]   sq_reg  [0:2];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [C-1:0] brush;
        logic [C-1:0] point;
        logic [C:0]   diff;
        logic [C:0]   mag_next;

        assign brush    = s_tdata[a*C +: C];
        assign point    = s_tdata[(a+3)*C +: C];
        assign diff     = {point[C-1], point} - {brush[C-1], brush};
        assign mag_next = diff[C] ? (~diff + (C + 1)'(1)) : diff;

        always_ff @(posedge aclk) begin
            if (ce) begin
                mag_reg[a] <= mag_next;
                sq_reg[a]  <= D'(mag_reg[a]) * D'(mag_reg[a]);
            end
        end
    end

    // stage 3: squared distance
    logic           s3_valid_reg;
    logic [D-1:0]   d2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            d2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // stage 4: radius test and partial products of d2 * inv
    logic [CW-1:0]              d2_ext;
    logic [CW-1:0]              r_ext;
    logic [SQR_RADIUS_BITS-1:0] d2_m;
    sfw_tag_t                   s4_tag_reg;
    logic [A_LO_BITS+B_LO_BITS-1:0] pp_ll_reg;
    logic [A_HI_BITS+B_LO_BITS-1:0] pp_hl_reg;
    logic [A_LO_BITS+B_HI_BITS-1:0] pp_lh_reg;
    logic [A_HI_BITS+B_HI_BITS-1:0] pp_hh_reg;

    assign d2_ext = CW'(d2_reg);
    assign r_ext  = CW'(sqr_radius_reg);
    assign d2_m   = d2_ext[SQR_RADIUS_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_tag_reg <= '0;
        end else if (ce) begin
            s4_tag_reg.valid  <= s3_valid_reg;
            s4_tag_reg.in_rad <= (d2_ext <= r_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pp_ll_reg <= (A_LO_BITS+B_LO_BITS)'(d2_m[A_LO_BITS-1:0])
                       * (A_LO_BITS+B_LO_BITS)'(inv_sqr_radius_reg[B_LO_BITS-1:0]);
            pp_hl_reg <= (A_HI_BITS+B_LO_BITS)'(d2_m[SQR_RADIUS_BITS-1:A_LO_BITS])
                       * (A_HI_BITS+B_LO_BITS)'(inv_sqr_radius_reg[B_LO_BITS-1:0]);
            pp_lh_reg <= (A_LO_BITS+B_HI_BITS)'(d2_m[A_LO_BITS-1:0])
                       * (A_LO_BITS+B_HI_BITS)'(inv_sqr_radius_reg[INV_BITS-1:B_LO_BITS]);
            pp_hh_reg <= (A_HI_BITS+B_HI_BITS)'(d2_m[SQR_RADIUS_BITS-1:A_LO_BITS])
                       * (A_HI_BITS+B_HI_BITS)'(inv_sqr_radius_reg[INV_BITS-1:B_LO_BITS]);
        end
    end

    // stage 5: full product
    sfw_tag_t              s5_tag_reg;
    logic [PROD_BITS-1:0]  prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_tag_reg <= '0;
        end else if (ce) begin
            s5_tag_reg <= s4_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= PROD_BITS'(pp_ll_reg)
                      + (PROD_BITS'(pp_hl_reg) << A_LO_BITS)
                      + (PROD_BITS'(pp_lh_reg) << B_LO_BITS)
                      + (PROD_BITS'(pp_hh_reg) << (A_LO_BITS + B_LO_BITS));
        end
    end

    // stage 6: saturate and form 1 - x
    logic        sat;
    logic [W:0]  x_val;
    logic [W:0]  rad_next;
    logic [W:0]  rad_reg;
    sfw_tag_t    s6_tag_reg;

    assign sat      = |prod_reg[PROD_BITS-1:INV_FRAC_BITS];
    assign x_val    = {1'b0, prod_reg[INV_FRAC_BITS-1:SH]};
    assign rad_next = (s5_tag_reg.in_rad && !sat) ? (ONE - x_val) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_tag_reg <= '0;
        end else if (ce) begin
            s6_tag_reg <= s5_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg <= rad_next;
        end
    end

    // valid bits travel alongside
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    logic [W:0]  root;
    sfw_tag_t    root_tag;

    sfw_isqrt_pipe #(
        .WEIGHT_FRAC_BITS (W)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (ce),
        .rad_in   (rad_reg),
        .tag_in   (s6_tag_reg),
        .root_out (root),
        .tag_out  (root_tag)
    );

    // output register
    logic        out_valid_reg;
    logic [W:0]  weight_reg;
    logic        in_rad_reg;

    assign ce = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= root_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            weight_reg <= root;
            in_rad_reg <= root_tag.in_rad;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = MDW'(weight_reg);
    assign m_tuser[0] = in_rad_reg;

endmodule

// ===== design/sfw_isqrt_pipe.sv =====
// Pipelined floor square root, one result bit per stage, with a sideband tag.
module sfw_isqrt_pipe
    import sfw_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [WEIGHT_FRAC_BITS:0]   rad_in,
    input  sfw_tag_t                    tag_in,
    output logic [WEIGHT_FRAC_BITS:0]   root_out,
    output sfw_tag_t                    tag_out
);

    localparam int W  = WEIGHT_FRAC_BITS;
    localparam int N  = W + 1;
    localparam int VW = 2 * W + 2;

    logic [VW-1:0] v_pipe   [0:N];
    logic [VW-1:0] res_pipe [0:N];
    sfw_tag_t      tag_pipe [0:N];

    assign v_pipe[0]   = VW'(rad_in) << W;
    assign res_pipe[0] = '0;
    assign tag_pipe[0] = tag_in;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (W - i));

        logic [VW-1:0] trial;
        logic [VW-1:0] v_next;
        logic [VW-1:0] res_next;
        logic [VW-1:0] v_reg;
        logic [VW-1:0] res_reg;
        sfw_tag_t      tag_reg;

        always_comb begin
            trial = res_pipe[i] + BIT;
            if (v_pipe[i] >= trial) begin
                v_next   = v_pipe[i] - trial;
                res_next = (res_pipe[i] >> 1) + BIT;
            end else begin
                v_next   = v_pipe[i];
                res_next = res_pipe[i] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg <= '0;
            end else if (en) begin
                tag_reg <= tag_pipe[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg   <= v_next;
                res_reg <= res_next;
            end
        end

        assign v_pipe[i+1]   = v_reg;
        assign res_pipe[i+1] = res_reg;
        assign tag_pipe[i+1] = tag_reg;
    end

    assign root_out = res_pipe[N][W:0];
    assign tag_out  = tag_pipe[N];

endmodule

// ===== design/sfw_checker.sv =====
// Port checker for the falloff weight block, bound to the top level.
module sfw_checker
    import sfw_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((WEIGHT_FRAC_BITS+8)/8)*8-1:0]  m_tdata,
    input logic [0:0]                             m_tuser
);

    localparam int W = WEIGHT_FRAC_BITS;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[W:0] == '0)
        else $error("nonzero weight outside the radius");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[W:0] <= ((W + 1)'(1) << W))
        else $error("weight above 1.0");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

endmodule

bind spherical_falloff_weight sfw_checker #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_sfw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
